@@ sv/drw_pkg.sv @@
package drw_pkg;

	localparam int DEFAULT_MAX_WIDTH  = 4096;
	localparam int DEFAULT_MAX_HEIGHT = 4096;

	localparam int NUM_REGS  = 6;
	localparam int IDX_W     = 3;
	localparam int REG_W     = 64;
	localparam int COEF_W    = 32;
	localparam int PROD_W    = 45;
	localparam int AFF_W     = 47;
	localparam int NUM_W     = 64;
	localparam int RES_W     = 32;

	// quotient bits: 20 integer + 12 fraction + 1 rounding
	localparam int QINT_BITS = 20;
	localparam int QFRAC_BITS = 13;
	localparam int DIV_STEPS = QINT_BITS + QFRAC_BITS;

	localparam int PROJ_LAT  = 4;
	localparam int DIV_LAT   = DIV_STEPS + 3;
	localparam int PIPE_LAT  = 1 + PROJ_LAT + DIV_LAT;

	localparam logic signed [RES_W-1:0] MINUS_ONE_Q12 = -32'sd4096;
	localparam logic signed [RES_W-1:0] RES_MAX = 32'sh7FFFFFFF;
	localparam logic signed [RES_W-1:0] RES_MIN = 32'sh80000000;

	typedef enum logic [IDX_W-1:0] {
		REG_ROW0_A = 3'd0,
		REG_ROW0_B = 3'd1,
		REG_ROW1_A = 3'd2,
		REG_ROW1_B = 3'd3,
		REG_ROW2_A = 3'd4,
		REG_ROW2_B = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic [15:0] depth;
		logic [11:0] column;
		logic [11:0] row;
	} in_item_t;

	typedef struct packed {
		logic signed [RES_W-1:0] src_x;
		logic signed [RES_W-1:0] src_y;
		logic                    valid_res;
		logic                    saturated;
	} out_item_t;

	typedef struct packed {
		logic neg;
		logic zden;
		logic npos;
		logic nneg;
		logic big;
	} div_flags_t;

endpackage

@@ sv/depth_reprojection_warp_top.sv @@
// Depth reprojection warp.
// Input channel (in_valid/in_ready/in_data): one beat per destination pixel,
// carrying depth (unsigned Q6.10), column and row. Output channel
// (out_valid/out_ready/out_data): one beat per input beat, in order, with
// src_x/src_y in signed Q20.12, valid_res and saturated.
// Config: cfg_we writes cfg_data into the register at cfg_index (0..5);
// out-of-range indexes are dropped. Write only while the pipe is empty.
// Throughput: one beat per cycle while the output is not stalled; the
// 33-step restoring divider is fully pipelined, one quotient bit per stage,
// x and y in parallel.
// Stall: the whole pipe freezes while out_valid is high and out_ready low;
// in_ready is low then, so nothing is lost or repeated.
// Reset: arst_n clears all valid bits and the coefficient registers to zero.
// Zero depth gives -1.0 on both coordinates, valid_res=0; a zero z or an
// out-of-range quotient clamps and sets saturated.
module depth_reprojection_warp_top #(
	parameter int MAX_WIDTH  = drw_pkg::DEFAULT_MAX_WIDTH,
	parameter int MAX_HEIGHT = drw_pkg::DEFAULT_MAX_HEIGHT
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  drw_pkg::in_item_t             in_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output drw_pkg::out_item_t            out_data,
	input  logic                          cfg_we,
	input  logic [drw_pkg::IDX_W-1:0]     cfg_index,
	input  logic [drw_pkg::REG_W-1:0]     cfg_data
);
	import drw_pkg::*;

	logic [REG_W-1:0] regs_q [0:NUM_REGS-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++) regs_q[i] <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ROW0_A: regs_q[0] <= cfg_data;
				REG_ROW0_B: regs_q[1] <= cfg_data;
				REG_ROW1_A: regs_q[2] <= cfg_data;
				REG_ROW1_B: regs_q[3] <= cfg_data;
				REG_ROW2_A: regs_q[4] <= cfg_data;
				REG_ROW2_B: regs_q[5] <= cfg_data;
				default: ;
			endcase
		end
	end

	// pipe advances as one; bubbles are not squeezed out
	logic en;
	assign en       = out_ready || !out_valid;
	assign in_ready = en;

	// valid and depth-present bits, stage 1 .. PIPE_LAT
	logic vld_q [1:PIPE_LAT];
	logic dv_q  [1:PIPE_LAT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 1; i <= PIPE_LAT; i++) vld_q[i] <= 1'b0;
		end else if (en) begin
			vld_q[1] <= in_valid;
			for (int i = 2; i <= PIPE_LAT; i++) vld_q[i] <= vld_q[i-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dv_q[1] <= (in_data.depth != '0);
			for (int i = 2; i <= PIPE_LAT; i++) dv_q[i] <= dv_q[i-1];
		end
	end

	// stage 1: capture, clamp column and row to the image
	logic [15:0] d_s1;
	logic [11:0] col_s1, row_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			d_s1   <= in_data.depth;
			col_s1 <= (int'(in_data.column) >= MAX_WIDTH) ? 12'(MAX_WIDTH - 1)
			                                               : in_data.column;
			row_s1 <= (int'(in_data.row) >= MAX_HEIGHT) ? 12'(MAX_HEIGHT - 1)
			                                             : in_data.row;
		end
	end

	// stages 2..5: x, y, z numerators
	logic signed [NUM_W-1:0] xn, yn, zn;

	drw_proj u_proj_x (
		.clk(clk), .en(en), .d(d_s1), .col(col_s1), .row(row_s1),
		.c0($signed(regs_q[0][31:0])), .c1($signed(regs_q[0][63:32])),
		.c2($signed(regs_q[1][31:0])), .c3($signed(regs_q[1][63:32])),
		.num(xn)
	);

	drw_proj u_proj_y (
		.clk(clk), .en(en), .d(d_s1), .col(col_s1), .row(row_s1),
		.c0($signed(regs_q[2][31:0])), .c1($signed(regs_q[2][63:32])),
		.c2($signed(regs_q[3][31:0])), .c3($signed(regs_q[3][63:32])),
		.num(yn)
	);

	drw_proj u_proj_z (
		.clk(clk), .en(en), .d(d_s1), .col(col_s1), .row(row_s1),
		.c0($signed(regs_q[4][31:0])), .c1($signed(regs_q[4][63:32])),
		.c2($signed(regs_q[5][31:0])), .c3($signed(regs_q[5][63:32])),
		.num(zn)
	);

	// divide x/z and y/z, rounded Q12 with clamping
	logic signed [RES_W-1:0] qx, qy;
	logic                    sx, sy;

	drw_div u_div_x (.clk(clk), .en(en), .num(xn), .den(zn), .res(qx), .sat(sx));
	drw_div u_div_y (.clk(clk), .en(en), .num(yn), .den(zn), .res(qy), .sat(sy));

	assign out_valid = vld_q[PIPE_LAT];

	always_comb begin
		if (dv_q[PIPE_LAT]) begin
			out_data.src_x     = qx;
			out_data.src_y     = qy;
			out_data.valid_res = 1'b1;
			out_data.saturated = sx || sy;
		end else begin
			out_data.src_x     = MINUS_ONE_Q12;
			out_data.src_y     = MINUS_ONE_Q12;
			out_data.valid_res = 1'b0;
			out_data.saturated = 1'b0;
		end
	end

	a_ready_follows_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready == (out_ready || !out_valid))
		else $error("in_ready does not track output stall");

	a_invalid_minus_one: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_data.valid_res) |->
		(out_data.src_x == MINUS_ONE_Q12 && out_data.src_y == MINUS_ONE_Q12
		 && !out_data.saturated))
		else $error("zero depth result malformed");

	a_stall_holds_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(qx) && $stable(qy)))
		else $error("pipe moved during stall");

endmodule

@@ sv/drw_proj.sv @@
module drw_proj (
	input  logic                                 clk,
	input  logic                                 en,
	input  logic [15:0]                          d,
	input  logic [11:0]                          col,
	input  logic [11:0]                          row,
	input  logic signed [drw_pkg::COEF_W-1:0]    c0,
	input  logic signed [drw_pkg::COEF_W-1:0]    c1,
	input  logic signed [drw_pkg::COEF_W-1:0]    c2,
	input  logic signed [drw_pkg::COEF_W-1:0]    c3,
	output logic signed [drw_pkg::NUM_W-1:0]     num
);
	import drw_pkg::*;

	logic signed [PROD_W-1:0] p0_s2, p1_s2;
	logic [15:0]              d_s2, d_s3;
	logic signed [AFF_W-1:0]  a_s3;
	logic signed [NUM_W-1:0]  m_s4, num_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			p0_s2  <= PROD_W'(c0) * PROD_W'($signed({1'b0, col}));
			p1_s2  <= PROD_W'(c1) * PROD_W'($signed({1'b0, row}));
			d_s2   <= d;
			a_s3   <= AFF_W'(p0_s2) + AFF_W'(p1_s2) + AFF_W'(c2);
			d_s3   <= d_s2;
			m_s4   <= NUM_W'(a_s3) * NUM_W'($signed({1'b0, d_s3}));
			// offset carries depth scale 2^10
			num_s5 <= m_s4 + (NUM_W'(c3) <<< 10);
		end
	end

	assign num = num_s5;

endmodule

@@ sv/drw_div.sv @@
module drw_div (
	input  logic                                clk,
	input  logic                                en,
	input  logic signed [drw_pkg::NUM_W-1:0]    num,
	input  logic signed [drw_pkg::NUM_W-1:0]    den,
	output logic signed [drw_pkg::RES_W-1:0]    res,
	output logic                                sat
);
	import drw_pkg::*;

	logic [NUM_W-1:0]      rem_s  [0:DIV_STEPS];
	logic [NUM_W-1:0]      ud_s   [0:DIV_STEPS];
	logic [DIV_STEPS-1:0]  feed_s [0:DIV_STEPS];
	logic [DIV_STEPS-1:0]  quo_s  [0:DIV_STEPS];
	div_flags_t            flg_s  [0:DIV_STEPS];

	logic [NUM_W-1:0] un, ud;

	assign un = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
	assign ud = den[NUM_W-1] ? NUM_W'(-den) : NUM_W'(den);

	// magnitudes and sign flags
	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0]       <= un >> QINT_BITS;
			feed_s[0]      <= {un[QINT_BITS-1:0], {QFRAC_BITS{1'b0}}};
			ud_s[0]        <= ud;
			quo_s[0]       <= '0;
			flg_s[0].neg   <= num[NUM_W-1] ^ den[NUM_W-1];
			flg_s[0].zden  <= (den == '0);
			flg_s[0].npos  <= !num[NUM_W-1] && (num != '0);
			flg_s[0].nneg  <= num[NUM_W-1];
			flg_s[0].big   <= 1'b0;
		end
	end

	// one restoring step per stage
	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
		logic [NUM_W:0] t;
		logic           ge;
		div_flags_t     nflg;
		assign t  = {rem_s[k], feed_s[k][DIV_STEPS-1]};
		assign ge = (t >= {1'b0, ud_s[k]});
		always_comb begin
			nflg = flg_s[k];
			if (k == 0) begin
				// integer part reaches 2^20
				nflg.big = (rem_s[k] >= ud_s[k]);
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1]  <= ge ? NUM_W'(t - {1'b0, ud_s[k]}) : NUM_W'(t);
				feed_s[k+1] <= feed_s[k] << 1;
				ud_s[k+1]   <= ud_s[k];
				quo_s[k+1]  <= {quo_s[k][DIV_STEPS-2:0], ge};
				flg_s[k+1]  <= nflg;
			end
		end
	end

	logic [DIV_STEPS-1:0] qr, lim, qsel_f1;
	logic                 satq_f1;
	div_flags_t           flg_f1;
	logic signed [RES_W-1:0] res_f2;
	logic                    sat_f2;

	assign qr  = DIV_STEPS'(({1'b0, quo_s[DIV_STEPS]} + 1'b1) >> 1);
	assign lim = flg_s[DIV_STEPS].neg ? DIV_STEPS'(33'h080000000) : DIV_STEPS'(33'h07FFFFFFF);

	always_ff @(posedge clk) begin
		if (en) begin
			satq_f1 <= flg_s[DIV_STEPS].big || (qr > lim);
			qsel_f1 <= (flg_s[DIV_STEPS].big || (qr > lim)) ? lim : qr;
			flg_f1  <= flg_s[DIV_STEPS];
			if (flg_f1.zden) begin
				sat_f2 <= 1'b1;
				if (flg_f1.npos)
					res_f2 <= RES_MAX;
				else if (flg_f1.nneg)
					res_f2 <= RES_MIN;
				else
					res_f2 <= '0;
			end else begin
				sat_f2 <= satq_f1;
				res_f2 <= flg_f1.neg ? RES_W'(-qsel_f1) : RES_W'(qsel_f1);
			end
		end
	end

	assign res = res_f2;
	assign sat = sat_f2;

endmodule

@@ tb/depth_reprojection_warp_top_tb.sv @@
module depth_reprojection_warp_top_tb;
	import drw_pkg::*;

	// register indexes past the list; the block must drop these writes
	localparam logic [IDX_W-1:0] IDX_SPARE_LO = 3'd6;
	localparam logic [IDX_W-1:0] IDX_SPARE_HI = 3'd7;
	localparam logic [COEF_W-1:0] Q24_ONE = 32'h0100_0000;

	// Expected-beat store plus a bit-exact projection/divide predictor.
	class warp_scoreboard;
		logic [REG_W-1:0] coefs [NUM_REGS];
		out_item_t        expected_q [$];
		int               errors;

		function new();
			foreach (coefs[i]) coefs[i] = '0;
			errors = 0;
		endfunction

		function void set_reg(logic [IDX_W-1:0] idx, logic [REG_W-1:0] val);
			if (idx < NUM_REGS) coefs[idx] = val;
		endfunction

		function longint coef_word(int k);
			logic [REG_W-1:0] w;
			w = coefs[k >> 1];
			if (k & 1) return longint'($signed(w[63:32]));
			return longint'($signed(w[31:0]));
		endfunction

		// d*(c0*col + c1*row + c2) + c3, scaled by 2^34
		function longint project(int base, longint d, longint col, longint rw);
			longint a;
			a = coef_word(base) * col + coef_word(base + 1) * rw + coef_word(base + 2);
			return d * a + coef_word(base + 3) * 1024;
		endfunction

		// num/den in Q12, round half away from zero, clamp to 32 bits
		function longint quotient_q12(longint num, longint den, inout bit sat);
			bit neg;
			longint unsigned un, ud, q, r, limit;
			if (den == 0) begin
				sat = 1;
				if (num > 0) return 64'sd2147483647;
				if (num < 0) return -64'sd2147483648;
				return 0;
			end
			neg = (num < 0) != (den < 0);
			un = (num < 0) ? -num : num;
			ud = (den < 0) ? -den : den;
			limit = neg ? 64'd2147483648 : 64'd2147483647;
			q = un / ud;
			r = un % ud;
			if (q >= (64'd1 << 20)) begin
				sat = 1;
				q = limit;
			end else begin
				for (int b = 0; b < 12; b++) begin
					r = r << 1;
					q = q << 1;
					if (r >= ud) begin
						r = r - ud;
						q = q | 1;
					end
				end
				if ((r << 1) >= ud) q = q + 1;
				if (q > limit) begin
					sat = 1;
					q = limit;
				end
			end
			if (neg) return -longint'(q);
			return longint'(q);
		endfunction

		function void note_pixel(in_item_t px);
			out_item_t exp_beat;
			longint x, y, z, d, c, rw;
			bit sat;
			sat = 0;
			c = (px.column >= DEFAULT_MAX_WIDTH) ? DEFAULT_MAX_WIDTH - 1 : px.column;
			rw = (px.row >= DEFAULT_MAX_HEIGHT) ? DEFAULT_MAX_HEIGHT - 1 : px.row;
			if (px.depth == 0) begin
				exp_beat.src_x = MINUS_ONE_Q12;
				exp_beat.src_y = MINUS_ONE_Q12;
				exp_beat.valid_res = 1'b0;
			end else begin
				d = px.depth;
				x = project(0, d, c, rw);
				y = project(4, d, c, rw);
				z = project(8, d, c, rw);
				exp_beat.src_x = RES_W'(quotient_q12(x, z, sat));
				exp_beat.src_y = RES_W'(quotient_q12(y, z, sat));
				exp_beat.valid_res = 1'b1;
			end
			exp_beat.saturated = sat;
			expected_q.push_back(exp_beat);
		endfunction

		task report(string msg);
			$display("mismatch @%0t: %s", $realtime, msg);
			errors++;
		endtask

		task check_beat(out_item_t got);
			out_item_t e;
			if (expected_q.size() == 0) begin
				report($sformatf("unexpected beat %h", got));
				return;
			end
			e = expected_q.pop_front();
			if (got.src_x !== e.src_x)
				report($sformatf("src_x got %h exp %h", got.src_x, e.src_x));
			if (got.src_y !== e.src_y)
				report($sformatf("src_y got %h exp %h", got.src_y, e.src_y));
			if (got.valid_res !== e.valid_res)
				report($sformatf("valid_res got %b exp %b", got.valid_res, e.valid_res));
			if (got.saturated !== e.saturated)
				report($sformatf("saturated got %b exp %b", got.saturated, e.saturated));
		endtask
	endclass

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_ready;
	in_item_t            in_data;
	logic                out_valid;
	logic                out_ready;
	out_item_t           out_data;
	logic                cfg_we;
	logic [IDX_W-1:0]    cfg_index;
	logic [REG_W-1:0]    cfg_data;

	warp_scoreboard sb = new();
	bit             calm;   // set for the closing stretch: no gaps, no stalls

	depth_reprojection_warp_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	// hard stop in case the pipe hangs
	initial begin
		#4000000;
		$display("depth_reprojection_warp_top_tb: FAIL");
		$finish;
	end

	// every output beat is checked against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) sb.check_beat(out_data);
	end

	// sink: ready in random runs broken by random stall bursts
	initial begin
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			out_ready <= 1'b1;
			repeat ($urandom_range(1, 24)) @(posedge clk);
			if (!calm) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 16)) @(posedge clk);
			end
		end
	end

	// one write, then a pause with cfg_we low so the next write starts on a fresh edge
	task write_reg(logic [IDX_W-1:0] idx, logic [REG_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we    <= 1'b0;
		sb.set_reg(idx, val);
		@(posedge clk);
	endtask

	// holds the beat until taken; a following send keeps valid high
	task send_pixel(logic [15:0] depth, logic [11:0] column, logic [11:0] row);
		in_item_t px;
		px.depth  = depth;
		px.column = column;
		px.row    = row;
		in_valid <= 1'b1;
		in_data  <= px;
		do @(posedge clk); while (!in_ready);
		sb.note_pixel(px);
	endtask

	task sender_gap(int cycles);
		in_valid <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	// pipe empty: every expected beat has come back
	task drain;
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.expected_q.size() != 0) @(posedge clk);
	endtask

	task load_matrix(logic [COEF_W-1:0] m [12]);
		write_reg(REG_ROW0_A, {m[1], m[0]});
		write_reg(REG_ROW0_B, {m[3], m[2]});
		write_reg(REG_ROW1_A, {m[5], m[4]});
		write_reg(REG_ROW1_B, {m[7], m[6]});
		write_reg(REG_ROW2_A, {m[9], m[8]});
		write_reg(REG_ROW2_B, {m[11], m[10]});
	endtask

	function logic [COEF_W-1:0] rand_coef(int style);
		case (style)
			0: return $urandom;
			1: return $signed($urandom) >>> $urandom_range(6, 30);
			default: case ($urandom_range(0, 3))
				0: return 32'h0000_0000;
				1: return 32'h7FFF_FFFF;
				2: return 32'h8000_0000;
				default: return 32'hFFFF_FFFF;
			endcase
		endcase
	endfunction

	// well-formed camera-like matrix: near identity with small random skew,
	// so most pixels land in range; other styles probe the clamp paths
	function void make_matrix(int style, output logic [COEF_W-1:0] m [12]);
		foreach (m[i]) m[i] = rand_coef(style);
		if (style == 1) begin
			m[0]  = Q24_ONE + ($signed($urandom) >>> 12);
			m[5]  = Q24_ONE + ($signed($urandom) >>> 12);
			m[10] = Q24_ONE + ($signed($urandom) >>> 10);
			m[8]  = $signed($urandom) >>> 20;
			m[9]  = $signed($urandom) >>> 20;
		end
	endfunction

	logic [COEF_W-1:0] mat [12];
	int                style;

	initial begin
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		in_data   = '0;
		cfg_we    = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		calm      = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset coefficients: zero numerators over zero z
		send_pixel(16'h0000, 12'd0, 12'd0);
		send_pixel(16'h0001, 12'd0, 12'd0);
		send_pixel(16'hFFFF, 12'hFFF, 12'hFFF);
		drain();

		// identity: src = (column, row)
		foreach (mat[i]) mat[i] = '0;
		mat[0] = Q24_ONE; mat[5] = Q24_ONE; mat[10] = Q24_ONE;
		load_matrix(mat);
		write_reg(IDX_SPARE_LO, 64'hFFFF_FFFF_FFFF_FFFF);   // must be dropped
		send_pixel(16'h0001, 12'd0, 12'd0);
		send_pixel(16'hFFFF, 12'hFFF, 12'hFFF);
		send_pixel(16'h8000, 12'hAAA, 12'h555);
		send_pixel(16'h0000, 12'h123, 12'h456);
		send_pixel(16'h5555, 12'h555, 12'hAAA);
		send_pixel(16'hAAAA, 12'hFFF, 12'h000);
		drain();

		// zero z: positive x saturates high, negative y low
		foreach (mat[i]) mat[i] = '0;
		mat[3] = 32'h0000_0001; mat[7] = 32'hFFFF_FFFF;
		load_matrix(mat);
		send_pixel(16'h0001, 12'd7, 12'd9);
		send_pixel(16'hFFFF, 12'hFFF, 12'hFFF);
		send_pixel(16'h0000, 12'd1, 12'd1);
		drain();

		// quotient out of range both ways, tiny z
		foreach (mat[i]) mat[i] = '0;
		mat[0] = 32'h7FFF_FFFF; mat[5] = 32'h8000_0000; mat[10] = 32'h0000_0001;
		load_matrix(mat);
		write_reg(IDX_SPARE_HI, 64'h1234_5678_9ABC_DEF0);
		send_pixel(16'hFFFF, 12'hFFF, 12'hFFF);
		send_pixel(16'h0001, 12'd1, 12'd1);
		send_pixel(16'h0400, 12'd0, 12'hFFF);
		drain();

		// extremes everywhere
		foreach (mat[i]) mat[i] = (i % 2) ? 32'h8000_0000 : 32'h7FFF_FFFF;
		load_matrix(mat);
		send_pixel(16'hFFFF, 12'hFFF, 12'hFFF);
		send_pixel(16'h0001, 12'd0, 12'hFFF);
		drain();

		// random phases; last one runs without gaps or stalls
		for (int p = 0; p < 9; p++) begin
			style = (p % 3 == 2) ? (p == 5 ? 2 : 0) : 1;
			make_matrix(style, mat);
			load_matrix(mat);
			if (p == 8) calm = 1'b1;
			for (int n = 0; n < 56; n++) begin
				send_pixel(($urandom_range(0, 9) == 0) ? 16'h0000 : 16'($urandom),
					12'($urandom), 12'($urandom));
				if (!calm && $urandom_range(0, 7) == 0) sender_gap($urandom_range(1, 16));
				// hold off until the pipe is empty, then resume
				if (p == 4 && n == 28) drain();
			end
			drain();
		end

		repeat (PIPE_LAT + 8) @(posedge clk);
		if (sb.errors == 0 && sb.expected_q.size() == 0) begin
			$display("depth_reprojection_warp_top_tb: PASS");
		end else begin
			$display("depth_reprojection_warp_top_tb: FAIL");
		end
		$finish;
	end

endmodule
